[hdl/dpq_pkg.sv]
`timescale 1ns / 1ps
package dpq_pkg;

	localparam int QUEUE_DEPTH = 64;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int OCC_W       = 7;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_POP    = 1'b1;

	typedef struct packed {
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [15:0] tag;
	} entry_t;

	typedef struct packed {
		logic insert;
		logic pop;
	} cell_ctrl_t;

	// year/month/day packed msb-first orders like the calendar
	function automatic logic [22:0] date_key(input entry_t e);
		date_key = {e.year, e.month, e.day};
	endfunction

endpackage

[hdl/dpq_cell.sv]
`timescale 1ns / 1ps
module dpq_cell (
	input  logic               clk,
	input  dpq_pkg::cell_ctrl_t ctrl,
	input  logic               occupied,
	input  logic               left_after,
	input  dpq_pkg::entry_t    new_entry,
	input  dpq_pkg::entry_t    left_entry,
	input  dpq_pkg::entry_t    right_entry,
	output dpq_pkg::entry_t    entry_q,
	output logic               after
);
	import dpq_pkg::*;

	// held entry sorts at or before the incoming one: it stays put
	assign after = occupied && (date_key(entry_q) <= date_key(new_entry));

	always_ff @(posedge clk) begin
		if (ctrl.insert) begin
			if (!after) begin
				entry_q <= left_after ? new_entry : left_entry;
			end
		end else if (ctrl.pop) begin
			entry_q <= right_entry;
		end
	end

endmodule

[hdl/date_priority_queue.sv]
`timescale 1ns / 1ps
// channel | handshake                  | word
// item    | item_valid / item_ready    | action, day, month, year, entry_tag
// result  | result_valid / result_ready| popped_valid, out_day, out_month, out_year,
//         |                            | out_tag, overflow, occupancy
//
// One word per cycle unless stalled: every cell compares its entry with the
// new one in parallel, so an insert or pop lands in the row at the next clock edge.
// Result appears in the cycle after the item is taken, from the output register.
// arst_n clears the entry count and result valid; cell contents are not reset.
// A stalled result blocks item_ready only while the output register is full.
module date_priority_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic        action,
	input  logic [4:0]  day,
	input  logic [3:0]  month,
	input  logic [13:0] year,
	input  logic [15:0] entry_tag,
	output logic        result_valid,
	input  logic        result_ready,
	output logic        popped_valid,
	output logic [4:0]  out_day,
	output logic [3:0]  out_month,
	output logic [13:0] out_year,
	output logic [15:0] out_tag,
	output logic        overflow,
	output logic [dpq_pkg::OCC_W-1:0] occupancy
);
	import dpq_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;
	logic             accept;
	logic             full;
	logic             empty;
	cell_ctrl_t       ctrl;
	entry_t           new_entry;
	entry_t           cell_entry [QUEUE_DEPTH];
	logic             cell_after [QUEUE_DEPTH];

	assign item_ready = !result_valid || result_ready;
	assign accept     = item_valid && item_ready;
	assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty      = (count_q == '0);

	assign ctrl.insert = accept && (action == ACT_INSERT) && !full;
	assign ctrl.pop    = accept && (action == ACT_POP) && !empty;

	assign new_entry.year  = year;
	assign new_entry.month = month;
	assign new_entry.day   = day;
	assign new_entry.tag   = entry_tag;

	always_comb begin
		count_nxt = count_q;
		if (ctrl.insert) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (ctrl.pop) begin
			count_nxt = count_q - CNT_W'(1);
		end
	end

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		entry_t left_e;
		entry_t right_e;
		logic   left_a;
		logic   occ;

		if (i == 0) begin : g_head
			assign left_e = new_entry;
			assign left_a = 1'b1;
		end else begin : g_mid
			assign left_e = cell_entry[i-1];
			assign left_a = cell_after[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign right_e = cell_entry[i];
		end else begin : g_body
			assign right_e = cell_entry[i+1];
		end

		assign occ = (count_q > CNT_W'(i));

		dpq_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.occupied    (occ),
			.left_after  (left_a),
			.new_entry   (new_entry),
			.left_entry  (left_e),
			.right_entry (right_e),
			.entry_q     (cell_entry[i]),
			.after       (cell_after[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			result_valid <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (accept) begin
				result_valid <= 1'b1;
			end else if (result_ready) begin
				result_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			popped_valid <= ctrl.pop;
			out_day      <= ctrl.pop ? cell_entry[0].day : '0;
			out_month    <= ctrl.pop ? cell_entry[0].month : '0;
			out_year     <= ctrl.pop ? cell_entry[0].year : '0;
			out_tag      <= ctrl.pop ? cell_entry[0].tag : '0;
			overflow     <= (action == ACT_INSERT) && full;
			occupancy    <= OCC_W'(count_nxt);
		end
	end

endmodule
